/* rtl/core/awn_pkg.sv */
package awn_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int ACC_WIDTH_DEF   = 24;

    localparam logic [22:0] PEAK_MAX = 23'h7FFFFF;

    // Coefficients of the quarter-wave sine polynomial, all in Q15 units.
    localparam int SIN_A = 51472;
    localparam int SIN_B = 21024;
    localparam int SIN_C = 2320;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [8:0]  harmonic;
        logic [15:0] amplitude;
        logic [9:0]  phase_offset;
        logic [9:0]  read_index;
    } awn_in_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [22:0]        peak_level;
        logic               was_scaled;
    } awn_out_t;

endpackage

/* rtl/core/additive_wavetable_normalizer_core.sv */
// Channel   Signals                       Direction  Moves
// in        in_valid/in_ready/in_data     into core  one command beat
// out       out_valid/out_ready/out_data  out        one result beat per command
// cfg       cfg_we/cfg_wdata              into core  threshold write, no wait
//
// Clear and add each sweep the table one entry a cycle; add goes through the
// read-modify-write of the table memory, which has one read and one write port.
// Read is raw or normalized; normalizing uses a 17-step restoring divider.
// After reset the table is zeroed by a pass over every entry; in_ready is low.
// One command at a time; a finished beat waits in the output register while
// the next command is accepted. TABLE_DEPTH must be a power of two.
module additive_wavetable_normalizer_core #(
    parameter int TABLE_DEPTH = awn_pkg::TABLE_DEPTH_DEF,
    parameter int ACC_WIDTH   = awn_pkg::ACC_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  awn_pkg::awn_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output awn_pkg::awn_out_t out_data,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int MAG_W = (ACC_WIDTH + 1 > 24) ? ACC_WIDTH + 1 : 24;
    localparam int NUM_W = ACC_WIDTH + 17;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CLEAR  = 8'b0000_0010,
        ST_WALK   = 8'b0000_0100,
        ST_DRAIN  = 8'b0000_1000,
        ST_RDADDR = 8'b0001_0000,
        ST_RDDATA = 8'b0010_0000,
        ST_DIV    = 8'b0100_0000,
        ST_FIN    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic init_reg, init_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next, k_reg, k_next, step_reg, step_next;
    logic [IDX_W-1:0] ridx_reg, ridx_next;
    logic [15:0] amp_reg, amp_next, thr_reg;
    logic [22:0] peak_reg, peak_next, walk_peak_reg, walk_peak_next;
    logic v5_reg;
    logic [IDX_W-1:0] i5_reg;
    logic signed [18:0] delta_reg;
    logic signed [15:0] sample_reg, sample_next;
    logic scaled_reg, scaled_next;
    logic out_valid_reg, out_valid_next;
    awn_pkg::awn_out_t out_data_reg, out_data_next;
    logic [24:0] rem_reg, rem_next;
    logic [16:0] nlo_reg, nlo_next, q_reg, q_next;
    logic neg_reg, neg_next;
    logic [4:0] dcnt_reg, dcnt_next;

    logic signed [ACC_WIDTH-1:0] mem [TABLE_DEPTH];
    logic signed [ACC_WIDTH-1:0] rdata_reg;
    logic re, we;
    logic [IDX_W-1:0] raddr, waddr;
    logic signed [ACC_WIDTH-1:0] wdata;

    logic s_vld, s_busy;
    logic signed [16:0] s_val;
    logic [IDX_W-1:0] s_tag;

    logic signed [33:0] prod;
    logic [33:0] pmag;
    logic [33:0] pround;
    logic signed [18:0] delta;
    logic signed [ACC_WIDTH:0] sum;
    logic signed [ACC_WIDTH-1:0] vsat;
    logic [ACC_WIDTH:0] vabs;
    logic [MAG_W-1:0] vmag;
    logic [22:0] vmag23;

    logic [ACC_WIDTH-1:0] emag;
    logic [NUM_W-1:0] num;
    logic [ACC_WIDTH-1:0] num_hi;
    logic [23:0] dv;
    logic ovf;
    logic [24:0] r2;
    logic ge;
    logic raw_sat;
    logic signed [15:0] raw_val;

    awn_sine #(.IDX_W(IDX_W)) u_sine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (state_reg == ST_WALK),
        .k        (k_reg),
        .tag      (cnt_reg),
        .out_vld  (s_vld),
        .out_sine (s_val),
        .out_tag  (s_tag),
        .busy     (s_busy)
    );

    function automatic logic signed [15:0] sat_quot(input logic [16:0] qm, input logic neg);
        logic signed [15:0] r;
        if (neg)
        begin
            r = (qm >= 17'd32768) ? -16'sd32768 : -$signed(qm[15:0]);
        end
        else
        begin
            r = (qm > 17'd32767) ? 16'sd32767 : $signed(qm[15:0]);
        end
        return r;
    endfunction

    // Partial product, rounded to a signed integer (Q18.0) with ties away from zero.
    always_comb
    begin
        prod   = $signed({1'b0, amp_reg}) * 34'(s_val);
        pmag   = prod[33] ? 34'(-prod) : 34'(prod);
        pround = pmag + 34'd16384;
        delta  = prod[33] ? -$signed({1'b0, pround[32:15]}) : $signed({1'b0, pround[32:15]});
    end

    // Accumulate into the entry read back from the table.
    always_comb
    begin
        sum = (ACC_WIDTH + 1)'(rdata_reg) + (ACC_WIDTH + 1)'(delta_reg);
        if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1])
        begin
            vsat = sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH - 1){1'b0}}}
                                  : {1'b0, {(ACC_WIDTH - 1){1'b1}}};
        end
        else
        begin
            vsat = sum[ACC_WIDTH-1:0];
        end
        vabs   = vsat[ACC_WIDTH-1] ? -(ACC_WIDTH + 1)'(vsat) : (ACC_WIDTH + 1)'(vsat);
        vmag   = MAG_W'(vabs);
        vmag23 = (vmag > MAG_W'(awn_pkg::PEAK_MAX)) ? awn_pkg::PEAK_MAX : vmag[22:0];
    end

    // Read path: the divider computes (2|e|*32768 + peak) / (2*peak).
    always_comb
    begin
        emag    = rdata_reg[ACC_WIDTH-1] ? ACC_WIDTH'(-rdata_reg) : ACC_WIDTH'(rdata_reg);
        num     = (NUM_W'(emag) << 16) + NUM_W'(peak_reg);
        num_hi  = num[NUM_W-1:17];
        dv      = {peak_reg, 1'b0};
        ovf     = MAG_W'(num_hi) >= MAG_W'(dv);
        r2      = {rem_reg[23:0], nlo_reg[16]};
        ge      = r2 >= {1'b0, dv};
        raw_sat = (rdata_reg[ACC_WIDTH-1:15] != {(ACC_WIDTH - 15){rdata_reg[ACC_WIDTH-1]}});
        if (raw_sat)
        begin
            raw_val = rdata_reg[ACC_WIDTH-1] ? -16'sd32768 : 16'sd32767;
        end
        else
        begin
            raw_val = rdata_reg[15:0];
        end
    end

    always_comb
    begin
        re    = s_vld || (state_reg == ST_RDADDR);
        raddr = s_vld ? s_tag : ridx_reg;
        we    = (state_reg == ST_CLEAR) || v5_reg;
        waddr = (state_reg == ST_CLEAR) ? cnt_reg : i5_reg;
        wdata = (state_reg == ST_CLEAR) ? '0 : vsat;
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        step_next      = step_reg;
        ridx_next      = ridx_reg;
        amp_next       = amp_reg;
        peak_next      = peak_reg;
        walk_peak_next = walk_peak_reg;
        sample_next    = sample_reg;
        scaled_next    = scaled_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        rem_next       = rem_reg;
        nlo_next       = nlo_reg;
        q_next         = q_reg;
        neg_next       = neg_reg;
        dcnt_next      = dcnt_reg;

        if (v5_reg && (vmag23 > walk_peak_reg))
        begin
            walk_peak_next = vmag23;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    amp_next    = in_data.amplitude;
                    ridx_next   = IDX_W'(in_data.read_index);
                    k_next      = IDX_W'(in_data.phase_offset);
                    step_next   = IDX_W'(in_data.harmonic);
                    cnt_next    = '0;
                    sample_next = '0;
                    scaled_next = 1'b0;
                    case (in_data.cmd)
                        awn_pkg::CMD_CLEAR: state_next = ST_CLEAR;
                        awn_pkg::CMD_ADD:
                        begin
                            walk_peak_next = '0;
                            state_next     = ST_WALK;
                        end
                        awn_pkg::CMD_READ:  state_next = ST_RDADDR;
                        default:            state_next = ST_FIN;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (&cnt_reg)
                begin
                    init_next = 1'b0;
                    if (init_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        peak_next  = '0;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_WALK:
            begin
                cnt_next = cnt_reg + 1'b1;
                k_next   = k_reg + step_reg;
                if (&cnt_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s_busy && !v5_reg)
                begin
                    peak_next  = walk_peak_reg;
                    state_next = ST_FIN;
                end
            end
            ST_RDADDR:
            begin
                state_next = ST_RDDATA;
            end
            ST_RDDATA:
            begin
                if ({7'd0, thr_reg} < peak_reg)
                begin
                    scaled_next = 1'b1;
                    neg_next    = rdata_reg[ACC_WIDTH-1];
                    if (ovf)
                    begin
                        sample_next = sat_quot(17'h1FFFF, rdata_reg[ACC_WIDTH-1]);
                        state_next  = ST_FIN;
                    end
                    else
                    begin
                        rem_next   = 25'(num_hi);
                        nlo_next   = num[16:0];
                        q_next     = '0;
                        dcnt_next  = '0;
                        state_next = ST_DIV;
                    end
                end
                else
                begin
                    sample_next = raw_val;
                    state_next  = ST_FIN;
                end
            end
            ST_DIV:
            begin
                rem_next  = ge ? (r2 - {1'b0, dv}) : r2;
                q_next    = {q_reg[15:0], ge};
                nlo_next  = {nlo_reg[15:0], 1'b0};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == 5'd16)
                begin
                    sample_next = sat_quot({q_reg[15:0], ge}, neg_reg);
                    state_next  = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.sample     = sample_reg;
                    out_data_next.peak_level = peak_reg;
                    out_data_next.was_scaled = scaled_reg;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            init_reg      <= 1'b1;
            cnt_reg       <= '0;
            peak_reg      <= '0;
            thr_reg       <= '0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            dcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            cnt_reg       <= cnt_next;
            peak_reg      <= peak_next;
            v5_reg        <= s_vld;
            out_valid_reg <= out_valid_next;
            dcnt_reg      <= dcnt_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        step_reg      <= step_next;
        ridx_reg      <= ridx_next;
        amp_reg       <= amp_next;
        walk_peak_reg <= walk_peak_next;
        i5_reg        <= s_tag;
        delta_reg     <= delta;
        sample_reg    <= sample_next;
        scaled_reg    <= scaled_next;
        out_data_reg  <= out_data_next;
        rem_reg       <= rem_next;
        nlo_reg       <= nlo_next;
        q_reg         <= q_next;
        neg_reg       <= neg_next;
    end

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!s_busy && !v5_reg))
        else $error("command accepted while the add pipeline is still busy");

    a_clear_no_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!v5_reg && !s_vld))
        else $error("clear sweep overlaps an accumulate write");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (dcnt_reg <= 5'd16))
        else $error("divider ran past its last quotient bit");

    a_scaled_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.was_scaled) |-> (out_data.peak_level != 23'd0))
        else $error("normalized beat reported with a zero peak");
`endif

endmodule

/* rtl/core/awn_sine.sv */
module awn_sine #(
    parameter int IDX_W = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  logic [IDX_W-1:0]   k,
    input  logic [IDX_W-1:0]   tag,
    output logic               out_vld,
    output logic signed [16:0] out_sine,
    output logic [IDX_W-1:0]   out_tag,
    output logic               busy
);

    logic [4:0] vld_reg;

    logic [16:0]      x1_reg, x2_reg, x3_reg, x4_reg;
    logic [1:0]       q1_reg, q2_reg, q3_reg, q4_reg;
    logic [IDX_W-1:0] t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic [16:0]      sq2_reg, sq3_reg;
    logic [15:0]      inner3_reg;
    logic [16:0]      mid4_reg;
    logic signed [16:0] sine_reg;

    logic [16:0] x_base, x_in;
    logic [33:0] sq_prod;
    logic [28:0] c_prod;
    logic [32:0] m_prod;
    logic [33:0] y_prod;
    logic [15:0] y_clamp;

    always_comb
    begin
        // Position inside the quarter wave, mirrored in odd quadrants.
        x_base = 17'(k[IDX_W-3:0]) << (17 - IDX_W);
        x_in   = k[IDX_W-2] ? (17'd32768 - x_base) : x_base;
        sq_prod = 34'(x1_reg) * 34'(x1_reg);
        c_prod  = 29'(sq2_reg) * 29'(awn_pkg::SIN_C);
        m_prod  = 33'(sq3_reg) * 33'(inner3_reg);
        y_prod  = 34'(x4_reg) * 34'(mid4_reg);
        y_clamp = (y_prod[33:15] > 19'd32767) ? 16'd32767 : y_prod[30:15];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg     <= x_in;
        q1_reg     <= k[IDX_W-1:IDX_W-2];
        t1_reg     <= tag;

        x2_reg     <= x1_reg;
        sq2_reg    <= sq_prod[31:15];
        q2_reg     <= q1_reg;
        t2_reg     <= t1_reg;

        x3_reg     <= x2_reg;
        sq3_reg    <= sq2_reg;
        inner3_reg <= 16'(awn_pkg::SIN_B) - 16'(c_prod[28:15]);
        q3_reg     <= q2_reg;
        t3_reg     <= t2_reg;

        x4_reg     <= x3_reg;
        mid4_reg   <= 17'(awn_pkg::SIN_A) - 17'(m_prod[32:15]);
        q4_reg     <= q3_reg;
        t4_reg     <= t3_reg;

        sine_reg   <= q4_reg[1] ? -$signed({1'b0, y_clamp}) : $signed({1'b0, y_clamp});
        t5_reg     <= t4_reg;
    end

    assign out_vld  = vld_reg[4];
    assign out_sine = sine_reg;
    assign out_tag  = t5_reg;
    assign busy     = |vld_reg;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH     = 1024;
    localparam int WDOG_MAX  = 5000;
    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef struct {
        awn_pkg::awn_in_t  beat;
        bit                typed;
        awn_pkg::awn_out_t want;
    } stim_row_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    awn_pkg::awn_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    awn_pkg::awn_out_t out_data;
    logic     cfg_we;
    logic [15:0] cfg_wdata;

    longint   wave_mdl [DEPTH];
    longint   peak_mdl;
    longint   thresh_mdl;
    awn_pkg::awn_out_t result_q[$];
    int       errors = 0;
    int       idle_count = 0;
    int       tx_idle_pct;
    int       rx_idle_pct;
    bit       hold_req;
    bit       hold_done;
    stim_row_t rows[$];

    additive_wavetable_normalizer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint sine_at(longint k);
        longint p, quad, x, x2, inner, mid, y;
        p = k * 4;
        quad = p / DEPTH;
        x = ((p % DEPTH) * 32768) / DEPTH;
        if (quad[0])
            x = 32768 - x;
        x2 = (x * x) >>> 15;
        inner = awn_pkg::SIN_B - ((x2 * awn_pkg::SIN_C) >>> 15);
        mid = awn_pkg::SIN_A - ((x2 * inner) >>> 15);
        y = (x * mid) >>> 15;
        if (y > 32767)
            y = 32767;
        return quad[1] ? -y : y;
    endfunction

    // Nearest, ties away from zero.
    function automatic longint div_round(longint num, longint den);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = (mag * 2 + den) / (den * 2);
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic awn_pkg::awn_out_t wave_apply(awn_pkg::awn_in_t b);
        awn_pkg::awn_out_t r;
        longint pk, v, mag, e, s;
        r.sample = '0;
        r.was_scaled = 1'b0;
        if (b.cmd == awn_pkg::CMD_CLEAR)
        begin
            foreach (wave_mdl[i])
                wave_mdl[i] = 0;
            peak_mdl = 0;
        end
        else if (b.cmd == awn_pkg::CMD_ADD)
        begin
            pk = 0;
            for (int i = 0; i < DEPTH; i++)
            begin
                v = wave_mdl[i] + div_round(longint'(b.amplitude) *
                    sine_at((longint'(b.harmonic) * i + b.phase_offset) % DEPTH), 32768);
                v = clamp(v, -8388608, 8388607);
                wave_mdl[i] = v;
                mag = (v < 0) ? -v : v;
                if (mag > pk)
                    pk = mag;
            end
            peak_mdl = (pk > awn_pkg::PEAK_MAX) ? awn_pkg::PEAK_MAX : pk;
        end
        else if (b.cmd == awn_pkg::CMD_READ)
        begin
            e = wave_mdl[b.read_index];
            if (peak_mdl > thresh_mdl)
            begin
                s = clamp(div_round(e * 32768, peak_mdl), -32768, 32767);
                r.was_scaled = 1'b1;
            end
            else
                s = clamp(e, -32768, 32767);
            r.sample = s[15:0];
        end
        r.peak_level = peak_mdl[22:0];
        return r;
    endfunction

    function automatic awn_pkg::awn_in_t mk(logic [1:0] c, int h, int a, int p, int ri);
        awn_pkg::awn_in_t b;
        b.cmd = c;
        b.harmonic = h[8:0];
        b.amplitude = a[15:0];
        b.phase_offset = p[9:0];
        b.read_index = ri[9:0];
        return b;
    endfunction

    function automatic awn_pkg::awn_out_t res(int s, int pk, bit sc);
        awn_pkg::awn_out_t r;
        r.sample = s[15:0];
        r.peak_level = pk[22:0];
        r.was_scaled = sc;
        return r;
    endfunction

    task automatic send_beat(awn_pkg::awn_in_t b, bit typed, awn_pkg::awn_out_t want);
        int gap;
        awn_pkg::awn_out_t e;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        do
            @(posedge clk);
        while (!in_ready);
        e = wave_apply(b);
        result_q.push_back(typed ? want : e);
    endtask

    task automatic drain_and_set(logic [15:0] thr);
        in_valid <= 1'b0;
        while (result_q.size() > 0)
            @(posedge clk);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_we <= 1'b0;
        thresh_mdl = thr;
    endtask

    function automatic awn_pkg::awn_in_t rand_beat();
        int roll;
        logic [1:0] c;
        int a;
        roll = $urandom_range(99);
        if (roll < 4)
            c = awn_pkg::CMD_CLEAR;
        else if (roll < 32)
            c = awn_pkg::CMD_ADD;
        else if (roll < 35)
            c = CMD_NONE;
        else
            c = awn_pkg::CMD_READ;
        a = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(65535);
        return mk(c, ($urandom_range(3) == 0) ? $urandom_range(8) : $urandom_range(511),
                  a, $urandom_range(1023), $urandom_range(1023));
    endfunction

    // Receiver side; a hold request stalls the result channel once for a long stretch.
    initial
    begin
        out_ready = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_done = 1'b1;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        awn_pkg::awn_out_t e;
        if (out_valid && out_ready)
        begin
            if (result_q.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: %h", $time, out_data);
                errors++;
            end
            else
            begin
                e = result_q.pop_front();
                if (out_data.sample !== e.sample)
                begin
                    $display("%0t: sample expected %0d actual %0d", $time,
                             e.sample, out_data.sample);
                    errors++;
                end
                if (out_data.peak_level !== e.peak_level)
                begin
                    $display("%0t: peak_level expected %0d actual %0d", $time,
                             e.peak_level, out_data.peak_level);
                    errors++;
                end
                if (out_data.was_scaled !== e.was_scaled)
                begin
                    $display("%0t: was_scaled expected %0b actual %0b", $time,
                             e.was_scaled, out_data.was_scaled);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_count <= 0;
        else
        begin
            idle_count <= idle_count + 1;
            if (idle_count >= WDOG_MAX)
            begin
                $display("FAIL additive_wavetable_normalizer_core");
                $finish;
            end
        end
    end

    initial
    begin
        awn_pkg::awn_out_t none;
        none = res(0, 0, 0);
        hold_req = 1'b0;
        tx_idle_pct = 29;
        rx_idle_pct = 50;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        foreach (wave_mdl[i])
            wave_mdl[i] = 0;
        peak_mdl = 0;
        thresh_mdl = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Known answers on an empty table, then predicted rows.
        rows.push_back('{mk(awn_pkg::CMD_READ, 0, 0, 0, 0), 1, res(0, 0, 0)});
        rows.push_back('{mk(awn_pkg::CMD_READ, 511, 65535, 1023, 1023), 1, res(0, 0, 0)});
        rows.push_back('{mk(CMD_NONE, 511, 65535, 1023, 1023), 1, res(0, 0, 0)});
        rows.push_back('{mk(awn_pkg::CMD_ADD, 1, 0, 0, 0), 1, res(0, 0, 0)});
        rows.push_back('{mk(awn_pkg::CMD_CLEAR, 511, 65535, 1023, 1023), 1, res(0, 0, 0)});
        rows.push_back('{mk(awn_pkg::CMD_ADD, 1, 65535, 0, 0), 0, none});
        rows.push_back('{mk(awn_pkg::CMD_READ, 0, 0, 0, 256), 0, none});
        rows.push_back('{mk(awn_pkg::CMD_READ, 0, 0, 0, 768), 0, none});
        rows.push_back('{mk(awn_pkg::CMD_READ, 0, 0, 0, 100), 0, none});
        rows.push_back('{mk(CMD_NONE, 3, 5, 7, 9), 0, none});
        rows.push_back('{mk(awn_pkg::CMD_ADD, 511, 1, 1023, 0), 0, none});
        rows.push_back('{mk(awn_pkg::CMD_ADD, 0, 32768, 512, 0), 0, none});
        rows.push_back('{mk(awn_pkg::CMD_READ, 0, 0, 0, 1023), 0, none});
        rows.push_back('{mk(awn_pkg::CMD_ADD, 256, 65535, 1, 0), 0, none});
        rows.push_back('{mk(awn_pkg::CMD_READ, 0, 0, 0, 1), 0, none});
        rows.push_back('{mk(awn_pkg::CMD_CLEAR, 0, 0, 0, 0), 1, res(0, 0, 0)});
        foreach (rows[i])
            send_beat(rows[i].beat, rows[i].typed, rows[i].want);

        // Push the sums into positive and then negative saturation.
        for (int i = 0; i < 130; i++)
            send_beat(mk(awn_pkg::CMD_ADD, 0, 65535, 256, 0), 0, none);
        send_beat(mk(awn_pkg::CMD_READ, 0, 0, 0, 5), 0, none);
        send_beat(mk(awn_pkg::CMD_CLEAR, 0, 0, 0, 0), 0, none);
        for (int i = 0; i < 130; i++)
            send_beat(mk(awn_pkg::CMD_ADD, 0, 65535, 768, 0), 0, none);
        send_beat(mk(awn_pkg::CMD_READ, 0, 0, 0, 5), 0, none);
        send_beat(mk(awn_pkg::CMD_CLEAR, 0, 0, 0, 0), 0, none);

        drain_and_set(16'hFFFF);
        for (int i = 0; i < 100; i++)
            send_beat(rand_beat(), 0, none);

        tx_idle_pct = 50;
        rx_idle_pct = 29;
        drain_and_set($urandom_range(65535));
        for (int i = 0; i < 100; i++)
            send_beat(rand_beat(), 0, none);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        drain_and_set(16'h0000);
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_beat(mk(awn_pkg::CMD_READ, 0, 0, 0, $urandom_range(1023)), 0, none);
        for (int i = 0; i < 90; i++)
            send_beat(rand_beat(), 0, none);

        in_valid <= 1'b0;
        while (result_q.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("PASS additive_wavetable_normalizer_core");
        else
            $display("FAIL additive_wavetable_normalizer_core");
        $finish;
    end
endmodule
